FILE: rtl/core/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and field widths for the tone sequence player.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned NowW   = 32;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CntW   = 7;
  localparam int unsigned RepW   = 8;
  localparam int unsigned FreqW  = 16;
  localparam int unsigned DurW   = 16;
  localparam int unsigned EntryW = FreqW + DurW;

  // Number of distinct values of the base_index field.
  localparam int unsigned IdxRange = 1 << IdxW;

  // Input tdata layout, lowest bit first.
  localparam int unsigned NowLsb  = 0;
  localparam int unsigned IdxLsb  = NowLsb + NowW;
  localparam int unsigned CntLsb  = IdxLsb + IdxW;
  localparam int unsigned RepLsb  = CntLsb + CntW;
  localparam int unsigned FreqLsb = RepLsb + RepW;
  localparam int unsigned DurLsb  = FreqLsb + FreqW;
  localparam int unsigned InUsedW = DurLsb + DurW;
  localparam int unsigned InDataW = ((InUsedW + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int unsigned OutUsedW = 1 + FreqW + 1;
  localparam int unsigned OutDataW = ((OutUsedW + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_WRITE = 2'd3
  } tsp_op_e;

  typedef struct packed {
    logic             playing;
    logic [FreqW-1:0] buzzer_frequency;
    logic             buzzer_on;
  } tsp_result_t;

endpackage

FILE: rtl/core/tsp_tone_mem.sv
// ----------------------------------------------------------------------------
// tsp_tone_mem
// Single-port tone table with a registered read port.
// ----------------------------------------------------------------------------
module tsp_tone_mem #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic                           we_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] addr_i,
  input  logic [tsp_pkg::EntryW-1:0]     wdata_i,
  output logic [tsp_pkg::EntryW-1:0]     rdata_o
);

  logic [tsp_pkg::EntryW-1:0] mem_q [TABLE_DEPTH];
  logic [tsp_pkg::EntryW-1:0] rdata_q;

  // Read data only changes on a read, so it holds while the result stalls.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tsp_seq.sv
// ----------------------------------------------------------------------------
// tsp_seq
// Melody sequencer: control state, tone fetch and the result stage.
// ----------------------------------------------------------------------------
module tsp_seq #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  tsp_pkg::tsp_op_e               op_i,
  input  logic [tsp_pkg::NowW-1:0]       now_ms_i,
  input  logic [tsp_pkg::IdxW-1:0]       base_index_i,
  input  logic [tsp_pkg::CntW-1:0]       tone_count_i,
  input  logic [tsp_pkg::RepW-1:0]       repeat_total_i,
  input  logic [tsp_pkg::FreqW-1:0]      entry_frequency_i,
  input  logic [tsp_pkg::DurW-1:0]       entry_duration_i,
  input  logic                           take_i,
  input  logic [tsp_pkg::EntryW-1:0]     mem_rdata_i,
  output logic                           mem_en_o,
  output logic                           mem_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_addr_o,
  output logic [tsp_pkg::EntryW-1:0]     mem_wdata_o,
  output logic                           res_valid_o,
  output tsp_pkg::tsp_result_t           res_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // base_index reduced modulo the table depth.
  logic [AW-1:0] mod_tbl [tsp_pkg::IdxRange];
  for (genvar g = 0; g < tsp_pkg::IdxRange; g++) begin : g_mod
    assign mod_tbl[g] = AW'(g % TABLE_DEPTH);
  end

  logic                       active_q, active_d;
  logic [AW-1:0]              base_q, base_d;
  logic [tsp_pkg::CntW-1:0]   pos_q, pos_d;
  logic [tsp_pkg::CntW-1:0]   len_q, len_d;
  logic [tsp_pkg::RepW-1:0]   rep_q, rep_d;
  logic [AW-1:0]              addr_q, addr_d;
  logic [tsp_pkg::NowW-1:0]   deadline_q, deadline_d;
  logic [tsp_pkg::FreqW-1:0]  freq_q, freq_d;
  logic [tsp_pkg::NowW-1:0]   tone_now_q, tone_now_d;
  logic                       s2_valid_q, s2_adv_q, s2_act_q;
  logic [tsp_pkg::FreqW-1:0]  s2_freq_q;

  logic                       pend;
  logic [tsp_pkg::FreqW-1:0]  freq_eff;
  logic [tsp_pkg::NowW-1:0]   dl_eff;
  logic                       done, restart, adv;
  logic [AW-1:0]              rd_addr;
  logic [tsp_pkg::FreqW-1:0]  res_freq;

  // A tone fetched by the previous item lands in the read data this cycle;
  // its frequency and deadline are folded in here before they are stored.
  assign pend     = s2_valid_q & s2_adv_q;
  assign freq_eff = pend ? mem_rdata_i[tsp_pkg::FreqW-1:0] : freq_q;
  assign dl_eff   = pend ? tone_now_q +
                           tsp_pkg::NowW'(mem_rdata_i[tsp_pkg::EntryW-1:tsp_pkg::FreqW])
                         : deadline_q;

  assign done    = (pos_q >= len_q);
  assign restart = done && (rep_q != '0) && (len_q != '0);
  assign rd_addr = restart ? base_q : addr_q;

  always_comb begin
    active_d    = active_q;
    base_d      = base_q;
    pos_d       = pos_q;
    len_d       = len_q;
    rep_d       = rep_q;
    addr_d      = addr_q;
    deadline_d  = dl_eff;
    freq_d      = freq_eff;
    tone_now_d  = tone_now_q;
    adv         = 1'b0;
    mem_en_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = rd_addr;
    mem_wdata_o = {entry_duration_i, entry_frequency_i};
    if (accept_i) begin
      case (op_i)
        tsp_pkg::OP_TICK: begin
          if (active_q && (now_ms_i > dl_eff)) begin
            if (done && !restart) begin
              active_d = 1'b0;
              freq_d   = '0;
            end else begin
              adv        = 1'b1;
              mem_en_o   = 1'b1;
              pos_d      = (restart ? '0 : pos_q) + 1'b1;
              rep_d      = restart ? rep_q - 1'b1 : rep_q;
              addr_d     = (rd_addr == AW'(TABLE_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
              tone_now_d = now_ms_i;
            end
          end
        end
        tsp_pkg::OP_START: begin
          active_d   = 1'b1;
          freq_d     = '0;
          base_d     = mod_tbl[base_index_i];
          addr_d     = mod_tbl[base_index_i];
          pos_d      = '0;
          len_d      = tone_count_i;
          rep_d      = (repeat_total_i == '0) ? '0 : repeat_total_i - 1'b1;
          deadline_d = '0;
        end
        tsp_pkg::OP_STOP: begin
          active_d = 1'b0;
          freq_d   = '0;
        end
        tsp_pkg::OP_WRITE: begin
          mem_en_o   = 1'b1;
          mem_we_o   = 1'b1;
          mem_addr_o = mod_tbl[base_index_i];
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      base_q     <= '0;
      pos_q      <= '0;
      len_q      <= '0;
      rep_q      <= '0;
      addr_q     <= '0;
      deadline_q <= '0;
      freq_q     <= '0;
      tone_now_q <= '0;
      s2_valid_q <= 1'b0;
      s2_adv_q   <= 1'b0;
      s2_act_q   <= 1'b0;
      s2_freq_q  <= '0;
    end else begin
      active_q   <= active_d;
      base_q     <= base_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      rep_q      <= rep_d;
      addr_q     <= addr_d;
      deadline_q <= deadline_d;
      freq_q     <= freq_d;
      tone_now_q <= tone_now_d;
      if (accept_i) begin
        s2_valid_q <= 1'b1;
        s2_adv_q   <= adv;
        s2_act_q   <= active_d;
        s2_freq_q  <= freq_d;
      end else if (take_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  assign res_freq                = s2_adv_q ? mem_rdata_i[tsp_pkg::FreqW-1:0] : s2_freq_q;
  assign res_valid_o             = s2_valid_q;
  assign res_o.playing           = s2_act_q;
  assign res_o.buzzer_frequency  = res_freq;
  assign res_o.buzzer_on         = (res_freq != '0);

endmodule

FILE: rtl/core/tone_sequence_player.sv
// ----------------------------------------------------------------------------
// tone_sequence_player
// Buzzer melody sequencer driven by tick, start, stop and table write items.
// ----------------------------------------------------------------------------
// The player takes one item per clock unless a waiting result cannot move
// on, and returns one result per item via the result stage and the output
// register. The tone table is a single-port synchronous memory: a due tick
// issues its tone read at transfer, and the fetched frequency and duration
// are merged into the state in the following cycle, where the next tick's
// deadline compare sees them directly. A result stage and an output register
// let input transfers continue while a finished result waits to be taken.
module tone_sequence_player #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // now_ms, base_index, tone_count, repeat_total, entry_frequency,
  // entry_duration, zero fill
  input  logic [tsp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // op
  input  logic [tsp_pkg::OpW-1:0]       s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // buzzer_on, buzzer_frequency, playing, zero fill
  output logic [tsp_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic                        accept;
  logic                        take;
  logic                        res_valid;
  tsp_pkg::tsp_result_t        res;
  logic                        mem_en, mem_we;
  logic [AW-1:0]               mem_addr;
  logic [tsp_pkg::EntryW-1:0]  mem_wdata, mem_rdata;
  logic                        out_valid_q;
  tsp_pkg::tsp_result_t        out_q;

  assign take            = res_valid & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~res_valid | take;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  tsp_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .op_i             (tsp_pkg::tsp_op_e'(s_axis_tuser_i)),
    .now_ms_i         (s_axis_tdata_i[tsp_pkg::NowLsb +: tsp_pkg::NowW]),
    .base_index_i     (s_axis_tdata_i[tsp_pkg::IdxLsb +: tsp_pkg::IdxW]),
    .tone_count_i     (s_axis_tdata_i[tsp_pkg::CntLsb +: tsp_pkg::CntW]),
    .repeat_total_i   (s_axis_tdata_i[tsp_pkg::RepLsb +: tsp_pkg::RepW]),
    .entry_frequency_i(s_axis_tdata_i[tsp_pkg::FreqLsb +: tsp_pkg::FreqW]),
    .entry_duration_i (s_axis_tdata_i[tsp_pkg::DurLsb +: tsp_pkg::DurW]),
    .take_i           (take),
    .mem_rdata_i      (mem_rdata),
    .mem_en_o         (mem_en),
    .mem_we_o         (mem_we),
    .mem_addr_o       (mem_addr),
    .mem_wdata_o      (mem_wdata),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  tsp_tone_mem #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_tone_mem (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(tsp_pkg::OutDataW - tsp_pkg::OutUsedW)'(0),
                            out_q.playing, out_q.buzzer_frequency, out_q.buzzer_on};

endmodule

FILE: rtl/core/tsp_checker.sv
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks for the tone sequence player, bound to the top level.
// ----------------------------------------------------------------------------
module tsp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [tsp_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  // No result is presented in the cycle after an edge that sees reset held.
  a_reset_quiet : assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // A sounding buzzer always belongs to an active melody.
  a_on_playing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[17])
    else $error("buzzer on while not playing");

  // A fresh result must trace back to an earlier input transfer.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result without a matching input transfer");

  // A stalled result holds its value.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind tone_sequence_player tsp_checker u_tsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
